FILE: hdl/erpsa_pkg.sv
// ----------------------------------------------------------------------------
// erpsa_pkg: shared types and constants of the ERP segment averager
// Beat payload structs, configuration register indexes and fixed widths.
// ----------------------------------------------------------------------------
`default_nettype none

package erpsa_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int COUNT_BITS  = 16;
  localparam int SUM_BITS    = SAMPLE_BITS + 24;
  localparam int POS_BITS    = 6;
  localparam int LEN_BITS    = 7;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  localparam logic [CFG_IDX_BITS-1:0] CFG_SEGMENT_LENGTH    = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BASELINE_MEAN     = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_HOLD_ON_RETRIGGER = 2'd2;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          trigger;
    logic                          clear;
  } in_beat_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] average;
    logic [POS_BITS-1:0]           position;
    logic [COUNT_BITS-1:0]         segments;
    logic                          last;
  } out_beat_t;

endpackage

`default_nettype wire

FILE: hdl/erpsa_div.sv
// ----------------------------------------------------------------------------
// erpsa_div: restoring unsigned divider, one quotient bit per cycle
// The upper dividend bits must already be below the divisor, so only the
// low QB bits are shifted through; the quotient holds until the next start.
// ----------------------------------------------------------------------------
`default_nettype none

module erpsa_div #(
  parameter int DVD_W = 40,
  parameter int DVS_W = 23,
  parameter int QB    = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dvd,
  input  wire logic [DVS_W-1:0] dvs,
  output logic                  done,
  output logic [QB-1:0]         quo
);

  localparam int CNT_W = $clog2(QB + 1);

  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [QB-1:0]    sh_r, sh_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             run_r, run_nxt;
  logic             done_r, done_nxt;

  always_comb begin
    logic [DVD_W-1:0] hi_part;
    logic [DVS_W:0]   trial;
    logic             qbit;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    sh_nxt   = sh_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = done_r;
    hi_part  = dvd >> QB;
    trial    = {rem_r, sh_r[QB-1]};
    qbit     = (trial >= {1'b0, dvs_r});
    if (start) begin
      rem_nxt  = hi_part[DVS_W-1:0];
      sh_nxt   = dvd[QB-1:0];
      dvs_nxt  = dvs;
      cnt_nxt  = '0;
      run_nxt  = 1'b1;
      done_nxt = 1'b0;
    end else if (run_r) begin
      // shift in one dividend bit, subtract where it fits
      rem_nxt = qbit ? DVS_W'(trial - {1'b0, dvs_r}) : trial[DVS_W-1:0];
      sh_nxt  = {sh_r[QB-2:0], qbit};
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(QB - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    sh_r  <= sh_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign quo  = sh_r;

endmodule

`default_nettype wire

FILE: hdl/erp_segment_averager_unit.sv
// ----------------------------------------------------------------------------
// erp_segment_averager_unit: event-related potential averaging over segments
// Collects triggered segments, accumulates them per index and emits the
// running average of the whole segment each time one completes.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one sample beat with trigger and clear flags; clear wipes the
//           sums, the segment count and any collection before the sample.
//   out_* : one beat per segment index once a segment is complete, in index
//           order, last set on the final index.
//   cfg_* : register writes (segment length, baseline mean, hold on
//           retrigger); always ready, write only while the block is idle.
// Flow: a sample that does not complete a segment is taken while idle, and
//   the block stays ready. A completing sample starts the per-segment pass:
//   it totals the segment from the sample memory, sets up the divisor, then
//   for each index adds the scaled sample to its sum (unless the count has
//   saturated) and forms the average with the bit-serial divider. in_ready stays low during the pass.
// Output register: results wait there while out_ready is low; the pass
//   holds at that index until the beat is taken.
// Reset: synchronous active low; registers return to their defaults (segment
//   length 64), counts and collection clear, no sums are held.
// ----------------------------------------------------------------------------
`default_nettype none

module erp_segment_averager_unit #(
  parameter int MAX_SEGMENT = 64
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire erpsa_pkg::in_beat_t                  in_data,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output erpsa_pkg::out_beat_t                      out_data,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [erpsa_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  wire logic [erpsa_pkg::LEN_BITS-1:0]       cfg_data
);

  localparam int SB    = erpsa_pkg::SAMPLE_BITS;
  localparam int CW    = erpsa_pkg::COUNT_BITS;
  localparam int SUM_W = erpsa_pkg::SUM_BITS;
  localparam int LEN_W = $clog2(MAX_SEGMENT + 1);
  localparam int IDX_W = (MAX_SEGMENT > 1) ? $clog2(MAX_SEGMENT) : 1;
  localparam int T_W   = SB + LEN_W;
  localparam int P_W   = SB + LEN_W + 1;
  localparam int DVS_W = CW + LEN_W;
  localparam logic [SB-1:0] Q_HALF = {1'b1, {(SB-1){1'b0}}};
  localparam logic [SB-1:0] Q_HI   = {1'b0, {(SB-1){1'b1}}};

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_TOT_RD  = 4'd1;
  localparam logic [3:0] S_TOT_ACC = 4'd2;
  localparam logic [3:0] S_PREP    = 4'd3;
  localparam logic [3:0] S_DIVSR   = 4'd4;
  localparam logic [3:0] S_RD      = 4'd5;
  localparam logic [3:0] S_MULT    = 4'd6;
  localparam logic [3:0] S_ACC     = 4'd7;
  localparam logic [3:0] S_DSTART  = 4'd8;
  localparam logic [3:0] S_DWAIT   = 4'd9;
  localparam logic [3:0] S_OUT     = 4'd10;

  // configuration
  logic [erpsa_pkg::LEN_BITS-1:0] seg_len_r;
  logic                           base_r;
  logic                           hold_r;

  // control state
  logic [3:0]       state_r, state_nxt;
  logic [LEN_W-1:0] fill_r, fill_nxt;
  logic             coll_r, coll_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [LEN_W-1:0] slen_r, slen_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             add_r, add_nxt;
  logic             first_r, first_nxt;
  logic             out_valid_r, out_valid_nxt;

  // datapath
  logic signed [T_W-1:0]   tot_r, tot_nxt;
  logic signed [P_W-1:0]   prod_r, prod_nxt;
  logic signed [SUM_W-1:0] acc_r, acc_nxt;
  logic [DVS_W-1:0]        dvs_r, dvs_nxt;
  logic                    neg_r, neg_nxt;
  erpsa_pkg::out_beat_t    out_r, out_nxt;

  // memories
  logic signed [SB-1:0]    coll_mem [MAX_SEGMENT];
  logic signed [SUM_W-1:0] sum_mem  [MAX_SEGMENT];
  logic signed [SB-1:0]    crd_r;
  logic signed [SUM_W-1:0] srd_r;
  logic                    cwr_en, crd_en, swr_en, srd_en;
  logic [IDX_W-1:0]        cwr_addr;
  logic signed [SUM_W-1:0] swr_data;

  // divider
  logic             div_start, div_done;
  logic [SUM_W-1:0] div_dvd;
  logic [SB-1:0]    div_quo;

  logic [LEN_W-1:0] act_len;
  logic             in_fire, idx_last;

  assign in_fire   = in_valid & in_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    if (seg_len_r == '0) begin
      act_len = LEN_W'(1);
    end else if (seg_len_r > erpsa_pkg::LEN_BITS'(MAX_SEGMENT)) begin
      act_len = LEN_W'(MAX_SEGMENT);
    end else begin
      act_len = seg_len_r[LEN_W-1:0];
    end
  end

  assign idx_last = (LEN_W'(idx_r) == act_len - LEN_W'(1));

  assign div_start = (state_r == S_DSTART);
  assign div_dvd   = acc_r[SUM_W-1] ? $unsigned(-acc_r) : $unsigned(acc_r);

  always_comb begin
    logic             coll_v;
    logic [LEN_W-1:0] fill_v;
    logic [CW-1:0]    cnt_v;
    logic signed [SUM_W-1:0] old_v;
    logic signed [SUM_W-1:0] base_v;
    logic signed [SB-1:0]    avg_v;
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    coll_nxt      = coll_r;
    count_nxt     = count_r;
    slen_nxt      = slen_r;
    idx_nxt       = idx_r;
    add_nxt       = add_r;
    first_nxt     = first_r;
    tot_nxt       = tot_r;
    prod_nxt      = prod_r;
    acc_nxt       = acc_r;
    dvs_nxt       = dvs_r;
    neg_nxt       = neg_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    cwr_en        = 1'b0;
    cwr_addr      = '0;
    crd_en        = 1'b0;
    srd_en        = 1'b0;
    swr_en        = 1'b0;
    swr_data      = acc_r;
    coll_v        = coll_r;
    fill_v        = fill_r;
    cnt_v         = count_r;
    old_v         = '0;
    base_v        = '0;
    avg_v         = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_data.clear) begin
            count_nxt = '0;
            slen_nxt  = '0;
            coll_v    = 1'b0;
            fill_v    = '0;
          end
          if (in_data.trigger && (!coll_v || !hold_r)) begin
            coll_v = 1'b1;
            fill_v = '0;
          end
          if (coll_v) begin
            if (fill_v < LEN_W'(MAX_SEGMENT)) begin
              cwr_en   = 1'b1;
              cwr_addr = fill_v[IDX_W-1:0];
              fill_v   = fill_v + LEN_W'(1);
            end
            if (fill_v >= act_len) begin
              // segment complete: start the per-segment pass
              state_nxt = S_TOT_RD;
              idx_nxt   = '0;
              tot_nxt   = '0;
              coll_v    = 1'b0;
              fill_v    = '0;
            end
          end
          coll_nxt = coll_v;
          fill_nxt = fill_v;
        end
      end
      S_TOT_RD: begin
        crd_en    = 1'b1;
        state_nxt = S_TOT_ACC;
      end
      S_TOT_ACC: begin
        tot_nxt = tot_r + T_W'(crd_r);
        if (idx_last) begin
          state_nxt = S_PREP;
        end else begin
          idx_nxt   = idx_r + IDX_W'(1);
          state_nxt = S_TOT_RD;
        end
      end
      S_PREP: begin
        // restart the sums when the segment length changed
        if (cnt_v != '0 && slen_r != act_len) begin
          cnt_v = '0;
        end
        add_nxt   = (cnt_v != erpsa_pkg::COUNT_MAX);
        first_nxt = (cnt_v == '0);
        if (cnt_v != erpsa_pkg::COUNT_MAX) begin
          cnt_v    = cnt_v + CW'(1);
          slen_nxt = act_len;
        end
        count_nxt = cnt_v;
        idx_nxt   = '0;
        state_nxt = S_DIVSR;
      end
      S_DIVSR: begin
        dvs_nxt   = DVS_W'(count_r * act_len);
        state_nxt = S_RD;
      end
      S_RD: begin
        crd_en    = 1'b1;
        srd_en    = 1'b1;
        state_nxt = S_MULT;
      end
      S_MULT: begin
        prod_nxt  = P_W'($signed(crd_r) * $signed({1'b0, act_len}));
        state_nxt = S_ACC;
      end
      S_ACC: begin
        if (add_r) begin
          old_v    = first_r ? '0 : srd_r;
          base_v   = base_r ? SUM_W'(tot_r) : '0;
          acc_nxt  = old_v + SUM_W'(prod_r) - base_v;
          swr_en   = 1'b1;
          swr_data = acc_nxt;
        end else begin
          acc_nxt = srd_r;
        end
        state_nxt = S_DSTART;
      end
      S_DSTART: begin
        neg_nxt   = acc_r[SUM_W-1];
        state_nxt = S_DWAIT;
      end
      S_DWAIT: begin
        if (div_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          // saturate to the signed sample range, then apply the sign
          if (neg_r) begin
            avg_v = (div_quo > Q_HALF) ? $signed(Q_HALF) : $signed(-div_quo);
          end else begin
            avg_v = div_quo[SB-1] ? $signed(Q_HI) : $signed(div_quo);
          end
          out_nxt.average  = avg_v;
          out_nxt.position = erpsa_pkg::POS_BITS'(idx_r);
          out_nxt.segments = count_r;
          out_nxt.last     = idx_last;
          out_valid_nxt    = 1'b1;
          if (idx_last) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + IDX_W'(1);
            state_nxt = S_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cwr_en) begin
      coll_mem[cwr_addr] <= in_data.sample;
    end
    if (crd_en) begin
      crd_r <= coll_mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (swr_en) begin
      sum_mem[idx_r] <= swr_data;
    end
    if (srd_en) begin
      srd_r <= sum_mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    tot_r  <= tot_nxt;
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    dvs_r  <= dvs_nxt;
    neg_r  <= neg_nxt;
    out_r  <= out_nxt;
    idx_r  <= idx_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      coll_r      <= 1'b0;
      count_r     <= '0;
      slen_r      <= '0;
      add_r       <= 1'b0;
      first_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      coll_r      <= coll_nxt;
      count_r     <= count_nxt;
      slen_r      <= slen_nxt;
      add_r       <= add_nxt;
      first_r     <= first_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_len_r <= erpsa_pkg::LEN_BITS'(64);
      base_r    <= 1'b0;
      hold_r    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        erpsa_pkg::CFG_SEGMENT_LENGTH:    seg_len_r <= cfg_data;
        erpsa_pkg::CFG_BASELINE_MEAN:     base_r    <= cfg_data[0];
        erpsa_pkg::CFG_HOLD_ON_RETRIGGER: hold_r    <= cfg_data[0];
        default: begin
          // no register here: drop the beat
        end
      endcase
    end
  end

  erpsa_div #(
    .DVD_W (SUM_W),
    .DVS_W (DVS_W),
    .QB    (SB)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .dvd   (div_dvd),
    .dvs   (dvs_r),
    .done  (div_done),
    .quo   (div_quo)
  );

endmodule

`default_nettype wire
